FILE: design/aes128_block_cipher_cbc_defines.svh
// Assertion macros shared by the AES-128 CBC block.
// No dependencies; included by the files that carry assertions.
`ifndef AES128_BLOCK_CIPHER_CBC_DEFINES_SVH
`define AES128_BLOCK_CIPHER_CBC_DEFINES_SVH
`ifndef SYNTHESIS
`define AESCBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AESCBC_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AESCBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define AESCBC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: design/aescbc_pkg.sv
// Types, constants, S-box tables and round functions of the AES-128 CBC block.
// No dependencies.
package aescbc_pkg;

    localparam int ROUNDS = 10;
    localparam int RND_W  = $clog2(ROUNDS + 1);

    typedef logic [RND_W-1:0] t_rnd;
    typedef logic [1:0]       t_func;
    typedef logic [1:0]       t_cfg_idx;
    typedef logic [127:0]     t_blk;

    localparam t_func FN_ENC     = 2'd0;
    localparam t_func FN_DEC     = 2'd1;
    localparam t_func FN_CBC_ENC = 2'd2;
    localparam t_func FN_CBC_DEC = 2'd3;

    localparam t_cfg_idx CFG_KEY_HIGH = 2'd0;
    localparam t_cfg_idx CFG_KEY_LOW  = 2'd1;
    localparam t_cfg_idx CFG_VARIANT  = 2'd2;

    localparam logic [7:0] TWEAK_RK4 = 8'h73;
    localparam logic [7:0] TWEAK_RK6 = 8'h09;
    localparam logic [7:0] TWEAK_RK8 = 8'hE4;

    typedef struct packed {
        logic accept;
        logic exp_init;
        logic exp_step;
        t_rnd exp_row;
        logic round_en;
        t_rnd round;
        logic last;
        logic out_from_round;
        logic out_from_hold;
    } t_cmd;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] get_byte(input t_blk s, input int k);
        return s[127-8*k -: 8];
    endfunction

    function automatic t_blk sub_bytes(input t_blk s, input logic inv);
        t_blk r;
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = inv ? INV_SBOX[get_byte(s, i)] : FWD_SBOX[get_byte(s, i)];
        end
        return r;
    endfunction

    function automatic t_blk shift_rows(input t_blk s, input logic inv);
        t_blk r;
        for (int c = 0; c < 4; c++) begin
            for (int w = 0; w < 4; w++) begin
                r[127-8*(4*c+w) -: 8] = inv ? get_byte(s, 4*((c + 4 - w) % 4) + w)
                                            : get_byte(s, 4*((c + w) % 4) + w);
            end
        end
        return r;
    endfunction

    function automatic t_blk mix_columns(input t_blk s, input logic inv);
        t_blk r;
        logic [7:0] a0, a1, a2, a3, u, v, x;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            if (inv) begin
                u = xtime(xtime(a0 ^ a2));
                v = xtime(xtime(a1 ^ a3));
                a0 = a0 ^ u;
                a2 = a2 ^ u;
                a1 = a1 ^ v;
                a3 = a3 ^ v;
            end
            x = a0 ^ a1 ^ a2 ^ a3;
            r[127-8*(4*c)   -: 8] = a0 ^ x ^ xtime(a0 ^ a1);
            r[127-8*(4*c+1) -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
            r[127-8*(4*c+2) -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
            r[127-8*(4*c+3) -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
        end
        return r;
    endfunction

    function automatic logic [7:0] rcon(input t_rnd k);
        logic [7:0] rc;
        case (k)
            4'd1:    rc = 8'h01;
            4'd2:    rc = 8'h02;
            4'd3:    rc = 8'h04;
            4'd4:    rc = 8'h08;
            4'd5:    rc = 8'h10;
            4'd6:    rc = 8'h20;
            4'd7:    rc = 8'h40;
            4'd8:    rc = 8'h80;
            4'd9:    rc = 8'h1b;
            4'd10:   rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    // One step of the key schedule: the next four words from the previous four.
    function automatic t_blk key_next(input t_blk w, input logic [7:0] rc);
        logic [31:0] t, n0, n1, n2, n3;
        t  = {FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]], FWD_SBOX[w[31:24]]}
             ^ {rc, 24'h0};
        n0 = w[127:96] ^ t;
        n1 = w[95:64] ^ n0;
        n2 = w[63:32] ^ n1;
        n3 = w[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    function automatic t_blk key_tweak(input t_blk w, input t_rnd k, input logic en);
        logic [7:0] m;
        case (k)
            4'd4:    m = TWEAK_RK4;
            4'd6:    m = TWEAK_RK6;
            4'd8:    m = TWEAK_RK8;
            default: m = 8'h00;
        endcase
        return w ^ {(en ? m : 8'h00), 120'h0};
    endfunction

endpackage

FILE: design/aescbc_in_if.sv
// Input channel of the AES-128 CBC block: one block word per handshake.
// Depends on nothing.
interface aescbc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        first_block;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [63:0] iv_high;
    logic [63:0] iv_low;

    modport source (output valid, func, first_block, block_high, block_low, iv_high, iv_low,
                    input ready);
    modport sink   (input valid, func, first_block, block_high, block_low, iv_high, iv_low,
                    output ready);
endinterface

FILE: design/aescbc_out_if.sv
// Output channel of the AES-128 CBC block: one result word per handshake.
// Depends on nothing.
interface aescbc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

FILE: design/aescbc_ctrl.sv
// Controller of the AES-128 CBC block: key expansion and round sequencing.
// Depends on aescbc_pkg and aes128_block_cipher_cbc_defines.svh.
`include "aes128_block_cipher_cbc_defines.svh"
module aescbc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  aescbc_pkg::t_cfg_idx i_cfg_idx,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output aescbc_pkg::t_cmd    o_cmd
);
    import aescbc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXP  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    localparam t_rnd LAST = t_rnd'(ROUNDS);

    logic [1:0] r_state, n_state;
    t_rnd       r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       out_free, cfg_hit;

    assign out_free    = !r_out_valid || i_out_ready;
    assign cfg_hit     = i_cfg_we && (i_cfg_idx == CFG_KEY_HIGH || i_cfg_idx == CFG_KEY_LOW
                                      || i_cfg_idx == CFG_VARIANT);
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.round   = r_cnt;
        o_cmd.exp_row = r_cnt;
        o_cmd.last    = (r_cnt == LAST);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = ST_RUN;
                    n_cnt   = t_rnd'(1);
                end
            end
            ST_EXP: begin
                o_cmd.exp_init = (r_cnt == '0);
                o_cmd.exp_step = (r_cnt != '0);
                if (r_cnt == LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + t_rnd'(1);
                end
            end
            ST_RUN: begin
                if (r_cnt == LAST) begin
                    if (out_free) begin
                        o_cmd.out_from_round = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.round_en = 1'b1;
                        n_state = ST_HOLD;
                    end
                end else begin
                    o_cmd.round_en = 1'b1;
                    n_cnt = r_cnt + t_rnd'(1);
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    o_cmd.out_from_hold = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // A key or variant write restarts the expansion from the new key.
        if (cfg_hit) begin
            n_state = ST_EXP;
            n_cnt   = '0;
        end
    end

    assign n_out_valid = (o_cmd.out_from_round || o_cmd.out_from_hold)
                         || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_EXP;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `AESCBC_ASSERT(a_accept_starts, i_clk, i_rst_n, (o_cmd.accept && !cfg_hit) |=> (r_state == ST_RUN && r_cnt == t_rnd'(1)), "accepted word did not start round one")
    `AESCBC_ASSERT(a_cnt_range, i_clk, i_rst_n, (r_cnt <= LAST), "round counter out of range")
    `AESCBC_ASSERT(a_exp_done, i_clk, i_rst_n, (r_state == ST_EXP && r_cnt == LAST && !cfg_hit) |=> (r_state == ST_IDLE), "key expansion did not finish")
    `AESCBC_ASSERT(a_out_single, i_clk, i_rst_n, !(o_cmd.out_from_round && o_cmd.out_from_hold), "two output loads at once")

endmodule

FILE: design/aescbc_dp.sv
// Datapath of the AES-128 CBC block: key registers, round-key rows, round unit, chain.
// Depends on aescbc_pkg.
module aescbc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  aescbc_pkg::t_cfg_idx i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  aescbc_pkg::t_cmd     i_cmd,
    input  logic [1:0]           i_func,
    input  logic                 i_first_block,
    input  logic [63:0]          i_block_high,
    input  logic [63:0]          i_block_low,
    input  logic [63:0]          i_iv_high,
    input  logic [63:0]          i_iv_low,
    output aescbc_pkg::t_blk     o_result
);
    import aescbc_pkg::*;

    logic [63:0] r_key_hi, r_key_lo;
    logic        r_variant;
    t_blk        r_chain;
    t_blk        r_rk [ROUNDS+1];
    t_blk        r_ek, r_st, r_prev, r_out;
    t_func       r_func;

    t_blk  blk, prev, pre, rk, rnd_out, t_enc, t_dec, fin_src, ek_next;
    t_rnd  rk_idx;
    logic  dec;

    assign blk  = {i_block_high, i_block_low};
    assign prev = i_first_block ? {i_iv_high, i_iv_low} : r_chain;
    assign pre  = (i_func == FN_CBC_ENC) ? (blk ^ prev) : blk;
    assign dec  = r_func[0];

    // Decryption walks the round keys from the top row down.
    assign rk_idx = dec ? (t_rnd'(ROUNDS) - i_cmd.round) : i_cmd.round;
    assign rk     = r_rk[rk_idx];

    always_comb begin
        t_enc = shift_rows(sub_bytes(r_st, 1'b0), 1'b0);
        if (!i_cmd.last) begin
            t_enc = mix_columns(t_enc, 1'b0);
        end
        t_enc = t_enc ^ rk;
        t_dec = sub_bytes(shift_rows(r_st, 1'b1), 1'b1) ^ rk;
        if (!i_cmd.last) begin
            t_dec = mix_columns(t_dec, 1'b1);
        end
        rnd_out = dec ? t_dec : t_enc;
    end

    assign fin_src = i_cmd.out_from_round ? rnd_out : r_st;
    assign ek_next = key_next(r_ek, rcon(i_cmd.exp_row));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi  <= '0;
            r_key_lo  <= '0;
            r_variant <= 1'b0;
            r_chain   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_HIGH: r_key_hi  <= i_cfg_data;
                    CFG_KEY_LOW:  r_key_lo  <= i_cfg_data;
                    CFG_VARIANT:  r_variant <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.accept && i_func == FN_CBC_DEC) begin
                r_chain <= blk;
            end
            if ((i_cmd.out_from_round || i_cmd.out_from_hold) && r_func == FN_CBC_ENC) begin
                r_chain <= fin_src;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_init) begin
            r_ek    <= {r_key_hi, r_key_lo};
            r_rk[0] <= {r_key_hi, r_key_lo};
        end
        if (i_cmd.exp_step) begin
            r_ek                 <= ek_next;
            r_rk[i_cmd.exp_row]  <= key_tweak(ek_next, i_cmd.exp_row, r_variant);
        end
        if (i_cmd.accept) begin
            r_st   <= pre ^ r_rk[i_func[0] ? t_rnd'(ROUNDS) : t_rnd'(0)];
            r_prev <= prev;
            r_func <= i_func;
        end
        if (i_cmd.round_en) begin
            r_st <= rnd_out;
        end
        if (i_cmd.out_from_round || i_cmd.out_from_hold) begin
            r_out <= (r_func == FN_CBC_DEC) ? (fin_src ^ r_prev) : fin_src;
        end
    end

    assign o_result = r_out;

endmodule

FILE: design/aes128_block_cipher_cbc.sv
// AES-128 block cipher with ECB-style block and CBC modes, one 128-bit word per item.
// The initial key addition is done as the word is taken and the ten rounds run one
// per cycle on a single shared round unit, the last loading the result register, or
// the state register while an earlier result still waits. A new word is taken only
// once the previous one has reached the result register. Reset (synchronous, active
// low) and each key or variant write expand the round keys with no word taken.
module aes128_block_cipher_cbc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  aescbc_pkg::t_cfg_idx i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    aescbc_in_if.sink            i_in,
    aescbc_out_if.source         o_out
);
    import aescbc_pkg::*;

    // The controller steps the key schedule and the rounds; the datapath holds
    // every piece of key, block and chain state. The chain register resets to zero.
    t_cmd cmd;
    t_blk result;

    aescbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    aescbc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .i_func        (i_in.func),
        .i_first_block (i_in.first_block),
        .i_block_high  (i_in.block_high),
        .i_block_low   (i_in.block_low),
        .i_iv_high     (i_in.iv_high),
        .i_iv_low      (i_in.iv_low),
        .o_result      (result)
    );

    // The result register holds its word until the sink takes it.
    assign o_out.result_high = result[127:64];
    assign o_out.result_low  = result[63:0];

endmodule
